// File: src/sector_nearest_focus_select_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sector focus search block.
// ----------------------------------------------------------------------------
`ifndef SECTOR_NEAREST_FOCUS_SELECT_ASSERT_SVH
`define SECTOR_NEAREST_FOCUS_SELECT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SNFS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

`define SNFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define SNFS_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define SNFS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: src/snfs_pkg.sv
// ----------------------------------------------------------------------------
// snfs_pkg
// Types and fixed constants of the sector focus search block.
// ----------------------------------------------------------------------------
`default_nettype none

package snfs_pkg;

   typedef enum logic [1:0] {
      DIR_RIGHT = 2'd0,
      DIR_LEFT  = 2'd1,
      DIR_UP    = 2'd2,
      DIR_DOWN  = 2'd3
   } dir_type;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_CAND  = 1'b1;

   // depth of the queue between front and back, and of the result queue
   localparam int CQ_DEPTH = 4;
   localparam int RQ_DEPTH = 2;

   typedef struct packed {
      logic start;  // opens a new search, clears the running best
      logic eval;   // candidate lies in the sector and is not skipped
      logic last;   // closes the search
   } cand_flags_type;

endpackage

`default_nettype wire

// File: src/snfs_fifo.sv
// ----------------------------------------------------------------------------
// snfs_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module snfs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: src/snfs_front.sv
// ----------------------------------------------------------------------------
// snfs_front
// Accepts beats, takes box centres, keeps the search origin and classifies
// each candidate against the direction sector.
// ----------------------------------------------------------------------------
`default_nettype none

module snfs_front #(
   parameter int COORD_BITS = 16,
   parameter int ID_BITS    = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic                         req_kind,
   input  logic signed [COORD_BITS-1:0] req_box_left,
   input  logic signed [COORD_BITS-1:0] req_box_right,
   input  logic signed [COORD_BITS-1:0] req_box_top,
   input  logic signed [COORD_BITS-1:0] req_box_bottom,
   input  logic [1:0]                   req_direction,
   input  logic                         req_is_current,
   input  logic [ID_BITS-1:0]           req_candidate_id,
   input  logic                         req_last,
   output logic                         cq_push,
   output snfs_pkg::cand_flags_type     cq_flags,
   output logic [COORD_BITS-1:0]        cq_ax,
   output logic [COORD_BITS-1:0]        cq_ay,
   output logic [ID_BITS-1:0]           cq_id,
   input  logic                         cq_full
);

   import snfs_pkg::*;

   localparam int C = COORD_BITS;

   // ---- stage A: centres of the incoming box
   logic signed [C:0]   sum_x, sum_y, diff_w;
   logic signed [C:0]   adj_x, adj_y, adj_w;
   logic                a_load, a_move;

   logic                a_valid_ff, a_valid_in;
   logic                a_kind_ff;
   logic signed [C-1:0] a_cx_ff, a_cy_ff, a_hw_ff;
   logic [1:0]          a_dir_ff;
   logic                a_skip_ff, a_last_ff;
   logic [ID_BITS-1:0]  a_id_ff;

   // halving rounds toward zero: add one to a negative sum before the shift
   assign sum_x  = {req_box_left[C-1], req_box_left} + {req_box_right[C-1], req_box_right};
   assign sum_y  = {req_box_top[C-1], req_box_top} + {req_box_bottom[C-1], req_box_bottom};
   assign diff_w = {req_box_right[C-1], req_box_right} - {req_box_left[C-1], req_box_left};
   assign adj_x  = sum_x + {{C{1'b0}}, sum_x[C]};
   assign adj_y  = sum_y + {{C{1'b0}}, sum_y[C]};
   assign adj_w  = diff_w + {{C{1'b0}}, diff_w[C]};

   // starts travel the queue too so the back clears its best in order
   assign a_move   = a_valid_ff & ~cq_full;
   assign req_full = a_valid_ff & ~a_move;
   assign a_load   = req_push & ~req_full;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (a_load) begin
         a_valid_in = 1'b1;
      end else if (a_move) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_kind_ff <= req_kind;
         a_cx_ff   <= adj_x[C:1];
         a_cy_ff   <= adj_y[C:1];
         a_hw_ff   <= req_direction[1] ? adj_w[C:1] : '0;
         a_dir_ff  <= req_direction;
         a_skip_ff <= req_is_current;
         a_last_ff <= req_last;
         a_id_ff   <= req_candidate_id;
      end
   end

   // ---- stage B: origin and sector test
   logic signed [C-1:0] org_x_ff, org_y_ff, org_hw_ff;
   dir_type             org_dir_ff;
   logic                org_load;

   logic signed [C:0]   dx, dy, ndx, ndy, x1, y1, ny1;
   logic signed [C+2:0] x1e, y1e, hwe, upper, lower;
   logic                hit;
   logic                is_cand;

   assign is_cand  = (a_kind_ff == KIND_CAND);
   assign org_load = a_move & (a_kind_ff == KIND_START);

   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff   <= '0;
         org_y_ff   <= '0;
         org_hw_ff  <= '0;
         org_dir_ff <= DIR_RIGHT;
      end else if (org_load) begin
         org_x_ff   <= a_cx_ff;
         org_y_ff   <= a_cy_ff;
         org_hw_ff  <= a_hw_ff;
         org_dir_ff <= dir_type'(a_dir_ff);
      end
   end

   assign dx  = {a_cx_ff[C-1], a_cx_ff} - {org_x_ff[C-1], org_x_ff};
   assign dy  = {a_cy_ff[C-1], a_cy_ff} - {org_y_ff[C-1], org_y_ff};
   assign ndx = -dx;
   assign ndy = -dy;

   // rotate so the search direction points along +x
   always_comb begin
      case (org_dir_ff)
         DIR_LEFT: begin
            x1 = ndx;
            y1 = dy;
         end
         DIR_UP: begin
            x1 = ndy;
            y1 = dx;
         end
         DIR_DOWN: begin
            x1 = dy;
            y1 = dx;
         end
         default: begin
            x1 = dx;
            y1 = dy;
         end
      endcase
   end

   assign x1e   = {{2{x1[C]}}, x1};
   assign y1e   = {{2{y1[C]}}, y1};
   assign hwe   = {{3{org_hw_ff[C-1]}}, org_hw_ff};
   assign upper = y1e - x1e - hwe;
   assign lower = y1e + x1e + hwe;
   assign hit   = ~x1[C] & (upper[C+2] | (upper == '0)) & ~lower[C+2];
   assign ny1   = -y1;

   assign cq_push        = a_move;
   assign cq_flags.start = ~is_cand;
   assign cq_flags.eval  = hit & ~a_skip_ff & is_cand;
   assign cq_flags.last  = a_last_ff & is_cand;
   assign cq_ax          = x1[C-1:0];
   assign cq_ay          = y1[C] ? ny1[C-1:0] : y1[C-1:0];
   assign cq_id          = a_id_ff;

endmodule

`default_nettype wire

// File: src/snfs_back.sv
// ----------------------------------------------------------------------------
// snfs_back
// Squares the rotated offsets, keeps the nearest hit and emits the result
// on the closing beat.
// ----------------------------------------------------------------------------
`default_nettype none

module snfs_back #(
   parameter int COORD_BITS = 16,
   parameter int ID_BITS    = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cq_empty,
   output logic                        cq_pop,
   input  snfs_pkg::cand_flags_type    cq_flags,
   input  logic [COORD_BITS-1:0]       cq_ax,
   input  logic [COORD_BITS-1:0]       cq_ay,
   input  logic [ID_BITS-1:0]          cq_id,
   output logic                        rq_push,
   input  logic                        rq_full,
   output logic                        rq_found,
   output logic [ID_BITS-1:0]          rq_id,
   output logic [2*COORD_BITS:0]       rq_dist
);

   import snfs_pkg::*;

   localparam int SQ_BITS   = 2 * COORD_BITS;
   localparam int DIST_BITS = 2 * COORD_BITS + 1;

   // ---- square stage
   logic               c_valid_ff, c_valid_in;
   cand_flags_type     c_flags_ff;
   logic [ID_BITS-1:0] c_id_ff;
   logic [SQ_BITS-1:0] c_sqx_ff, c_sqy_ff;
   logic [SQ_BITS-1:0] sq_x, sq_y;
   logic               c_fire;

   assign sq_x   = cq_ax * cq_ax;
   assign sq_y   = cq_ay * cq_ay;
   assign c_fire = c_valid_ff & (~c_flags_ff.last | ~rq_full);
   assign cq_pop = ~cq_empty & (~c_valid_ff | c_fire);

   always_comb begin
      c_valid_in = c_valid_ff;
      if (cq_pop) begin
         c_valid_in = 1'b1;
      end else if (c_fire) begin
         c_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cq_pop) begin
         c_flags_ff <= cq_flags;
         c_id_ff    <= cq_id;
         c_sqx_ff   <= sq_x;
         c_sqy_ff   <= sq_y;
      end
   end

   // ---- running best
   logic                 have_ff, have_in;
   logic [DIST_BITS-1:0] best_dist_ff, best_dist_in;
   logic [ID_BITS-1:0]   best_id_ff, best_id_in;
   logic [DIST_BITS-1:0] cand_dist;
   logic                 better;
   logic                 upd_have;
   logic [DIST_BITS-1:0] upd_dist;
   logic [ID_BITS-1:0]   upd_id;

   assign cand_dist = {1'b0, c_sqx_ff} + {1'b0, c_sqy_ff};
   // strict compare keeps the earliest hit on a tie
   assign better = c_flags_ff.eval & (~have_ff | (cand_dist < best_dist_ff));

   always_comb begin
      upd_have = have_ff | better;
      upd_dist = better ? cand_dist : best_dist_ff;
      upd_id   = better ? c_id_ff : best_id_ff;
   end

   always_comb begin
      have_in      = have_ff;
      best_dist_in = best_dist_ff;
      best_id_in   = best_id_ff;
      if (c_fire) begin
         if (c_flags_ff.last | c_flags_ff.start) begin
            have_in      = 1'b0;
            best_dist_in = '1;
            best_id_in   = '0;
         end else begin
            have_in      = upd_have;
            best_dist_in = upd_dist;
            best_id_in   = upd_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         best_dist_ff <= '1;
         best_id_ff   <= '0;
      end else begin
         have_ff      <= have_in;
         best_dist_ff <= best_dist_in;
         best_id_ff   <= best_id_in;
      end
   end

   assign rq_push  = c_fire & c_flags_ff.last;
   assign rq_found = upd_have;
   assign rq_id    = upd_have ? upd_id : '0;
   assign rq_dist  = upd_have ? upd_dist : '0;

endmodule

`default_nettype wire

// File: src/sector_nearest_focus_select.sv
// ----------------------------------------------------------------------------
// sector_nearest_focus_select: directional nearest-box focus search
// Throughput: one beat per cycle while no queue is full, starts and candidates
// alike. A result's path: stage A, candidate queue, square stage, result queue.
// Synchronous reset clears origin (0,0, right, width 0), best and all queues.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sector_nearest_focus_select_assert.svh"

module sector_nearest_focus_select #(
   parameter int COORD_BITS = 16,
   parameter int ID_BITS    = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic                         req_kind,
   input  logic signed [COORD_BITS-1:0] req_box_left,
   input  logic signed [COORD_BITS-1:0] req_box_right,
   input  logic signed [COORD_BITS-1:0] req_box_top,
   input  logic signed [COORD_BITS-1:0] req_box_bottom,
   input  logic [1:0]                   req_direction,
   input  logic                         req_is_current,
   input  logic [ID_BITS-1:0]           req_candidate_id,
   input  logic                         req_last,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic                         rsp_found,
   output logic [ID_BITS-1:0]           rsp_chosen_id,
   output logic [2*COORD_BITS:0]        rsp_best_distance
);

   import snfs_pkg::*;

   localparam int DIST_BITS = 2 * COORD_BITS + 1;
   localparam int FLAG_BITS = $bits(cand_flags_type);
   localparam int CQ_WIDTH  = FLAG_BITS + 2 * COORD_BITS + ID_BITS;
   localparam int RQ_WIDTH  = 1 + ID_BITS + DIST_BITS;

   // front to back queue
   logic                  cq_push, cq_full, cq_pop, cq_empty;
   cand_flags_type        fq_flags, bq_flags;
   logic [COORD_BITS-1:0] fq_ax, fq_ay, bq_ax, bq_ay;
   logic [ID_BITS-1:0]    fq_id, bq_id;
   logic [CQ_WIDTH-1:0]   cq_wdata, cq_rdata;

   // result queue
   logic                  rq_push, rq_full;
   logic                  rq_found;
   logic [ID_BITS-1:0]    rq_id;
   logic [DIST_BITS-1:0]  rq_dist;
   logic [RQ_WIDTH-1:0]   rq_wdata, rq_rdata;

   snfs_front #(
      .COORD_BITS (COORD_BITS),
      .ID_BITS    (ID_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_kind         (req_kind),
      .req_box_left     (req_box_left),
      .req_box_right    (req_box_right),
      .req_box_top      (req_box_top),
      .req_box_bottom   (req_box_bottom),
      .req_direction    (req_direction),
      .req_is_current   (req_is_current),
      .req_candidate_id (req_candidate_id),
      .req_last         (req_last),
      .cq_push          (cq_push),
      .cq_flags         (fq_flags),
      .cq_ax            (fq_ax),
      .cq_ay            (fq_ay),
      .cq_id            (fq_id),
      .cq_full          (cq_full)
   );

   assign cq_wdata = {fq_flags, fq_ax, fq_ay, fq_id};

   snfs_fifo #(
      .WIDTH (CQ_WIDTH),
      .DEPTH (CQ_DEPTH)
   ) u_cand_q (
      .clock     (clock),
      .reset     (reset),
      .push      (cq_push),
      .push_data (cq_wdata),
      .full      (cq_full),
      .pop       (cq_pop),
      .pop_data  (cq_rdata),
      .empty     (cq_empty)
   );

   assign bq_flags = cand_flags_type'(cq_rdata[CQ_WIDTH-1 -: FLAG_BITS]);
   assign bq_ax    = cq_rdata[ID_BITS + 2*COORD_BITS - 1 -: COORD_BITS];
   assign bq_ay    = cq_rdata[ID_BITS + COORD_BITS - 1 -: COORD_BITS];
   assign bq_id    = cq_rdata[ID_BITS-1:0];

   snfs_back #(
      .COORD_BITS (COORD_BITS),
      .ID_BITS    (ID_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cq_empty (cq_empty),
      .cq_pop   (cq_pop),
      .cq_flags (bq_flags),
      .cq_ax    (bq_ax),
      .cq_ay    (bq_ay),
      .cq_id    (bq_id),
      .rq_push  (rq_push),
      .rq_full  (rq_full),
      .rq_found (rq_found),
      .rq_id    (rq_id),
      .rq_dist  (rq_dist)
   );

   assign rq_wdata = {rq_found, rq_id, rq_dist};

   snfs_fifo #(
      .WIDTH (RQ_WIDTH),
      .DEPTH (RQ_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rq_push),
      .push_data (rq_wdata),
      .full      (rq_full),
      .pop       (rsp_pop),
      .pop_data  (rq_rdata),
      .empty     (rsp_empty)
   );

   assign rsp_found         = rq_rdata[RQ_WIDTH-1];
   assign rsp_chosen_id     = rq_rdata[DIST_BITS + ID_BITS - 1 -: ID_BITS];
   assign rsp_best_distance = rq_rdata[DIST_BITS-1:0];

   // a result with no hit carries zero id and distance
   `SNFS_ASSERT_IMPLIES(a_nohit_zero, clock, reset, !rsp_empty && !rsp_found, rsp_chosen_id == '0 && rsp_best_distance == '0)
   // input back-pressure only when the candidate queue is full
   `SNFS_ASSERT_IMPLIES(a_full_cause, clock, reset, req_full, cq_full)
   // no beat is lost into a full queue
   `SNFS_ASSERT_IMPLIES(a_cq_room, clock, reset, cq_push, !cq_full)
   `SNFS_ASSERT_IMPLIES(a_rq_room, clock, reset, rq_push, !rq_full)
   // a pushed result is visible in the next cycle
   `SNFS_ASSERT_NEXT(a_rq_visible, clock, reset, rq_push, !rsp_empty)

endmodule

`default_nettype wire
